// File: sv/dss_pkg.sv
// Shared types and constants of the delimiter string scanner.
package dss_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_TERM_LEN   = 2'd0;
    localparam logic [1:0] CFG_TERM_BYTES = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

    // Register reset values
    localparam logic [3:0]  RST_TERM_LEN   = 4'd2;
    localparam logic [63:0] RST_TERM_BYTES = 64'h0000_0000_0000_0A0D;
    localparam logic [15:0] RST_MAX_LENGTH = 16'd64;

    // Why a scan ended
    typedef enum logic [1:0] {
        CAUSE_TERM = 2'd0,
        CAUSE_FULL = 2'd1,
        CAUSE_ERR  = 2'd2
    } t_cause;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_FLUSH,
        S_TAIL
    } t_state;

    // Terminator bytes, byte 0 first
    typedef logic [7:0][7:0] t_term;

    // One result word
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        scan_done;
        t_cause      end_cause;
        logic [15:0] final_count;
        logic        last_of_run;
    } t_result;

    // Commands from the sequencer to the result stage
    typedef struct packed {
        logic        put;        // new payload byte
        logic [7:0]  put_byte;
        logic        fin;        // close the run of this input
        logic        fin_done;   // scan ends with it
        t_cause      fin_cause;
        logic [15:0] fin_count;
    } t_emit_cmd;

    // Result stage status back to the sequencer
    typedef struct packed {
        logic can_put;
        logic can_fin;
    } t_emit_stat;

endpackage

// File: sv/dss_emit.sv
// Result stage: one pending payload byte plus the output register.
module dss_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dss_pkg::t_emit_cmd   i_cmd,
    output dss_pkg::t_emit_stat  o_stat,
    input  logic                 i_ready,
    output logic                 o_valid,
    output dss_pkg::t_result     o_result
);

    logic             r_out_v;
    logic             n_out_v;
    dss_pkg::t_result r_out;
    dss_pkg::t_result n_out;
    logic             r_pend_v;
    logic             n_pend_v;
    logic [7:0]       r_pend_byte;
    logic [7:0]       n_pend_byte;
    logic             w_can_push;

    // output slot frees when empty or taken this cycle
    assign w_can_push     = !r_out_v || i_ready;
    assign o_stat.can_put = !r_pend_v || w_can_push;
    assign o_stat.can_fin = w_can_push;

    // pending byte is held until we know whether it closes the run
    always_comb begin
        n_out_v     = r_out_v && !i_ready;
        n_out       = r_out;
        n_pend_v    = r_pend_v;
        n_pend_byte = r_pend_byte;
        if (i_cmd.put) begin
            if (r_pend_v) begin
                n_out_v             = 1'b1;
                n_out.out_byte      = r_pend_byte;
                n_out.byte_valid    = 1'b1;
                n_out.scan_done     = 1'b0;
                n_out.end_cause     = dss_pkg::CAUSE_TERM;
                n_out.final_count   = 16'd0;
                n_out.last_of_run   = 1'b0;
            end
            n_pend_v    = 1'b1;
            n_pend_byte = i_cmd.put_byte;
        end else if (i_cmd.fin) begin
            if (r_pend_v || i_cmd.fin_done) begin
                n_out_v           = 1'b1;
                n_out.out_byte    = r_pend_v ? r_pend_byte : 8'd0;
                n_out.byte_valid  = r_pend_v;
                n_out.scan_done   = i_cmd.fin_done;
                n_out.end_cause   = i_cmd.fin_done ? i_cmd.fin_cause : dss_pkg::CAUSE_TERM;
                n_out.final_count = i_cmd.fin_done ? i_cmd.fin_count : 16'd0;
                n_out.last_of_run = 1'b1;
            end
            n_pend_v = 1'b0;
        end
    end

    // control flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
        end
    end

    // payload flops
    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_pend_byte <= n_pend_byte;
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

// File: sv/delimiter_string_scanner_core.sv
// One item at a time: o_ready is high only in S_IDLE, so a new input word waits until the
// last is through. A partial match or a scan end without flush visits S_DECIDE only; a read
// error adds S_FLUSH, a plain byte S_FLUSH and S_TAIL; S_FLUSH repeats per held byte.
// Result words leave through a one-word output register; a stalled output stalls the flush.
// Reset (i_rst_n low, synchronous): match index and payload count cleared, registers
// return to term_len 2, terminator 0x0A0D, max_length 64.
module delimiter_string_scanner_core #(
    parameter int MAX_TERM_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input word channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_read_error,
    // result word channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_scan_done,
    output logic [1:0]  o_end_cause,
    output logic [15:0] o_final_count,
    output logic        o_last_of_run
);

    localparam int IW = $clog2(MAX_TERM_BYTES + 1);

    // configuration
    logic [3:0]     r_term_len;
    dss_pkg::t_term r_term_bytes;
    logic [15:0]    r_max_len;

    // scan state
    dss_pkg::t_state r_state;
    dss_pkg::t_state n_state;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   n_idx;
    logic [IW-1:0]   r_i;
    logic [IW-1:0]   n_i;
    logic [15:0]     r_cnt;
    logic [15:0]     n_cnt;
    logic [7:0]      r_c;
    logic            r_err;

    logic                 w_accept;
    logic [3:0]           w_len;
    logic                 w_full;
    logic [7:0]           w_term_idx;
    logic [7:0]           w_term_i;
    logic [3:0]           w_idx_inc;
    dss_pkg::t_emit_cmd   w_cmd;
    dss_pkg::t_emit_stat  w_stat;
    dss_pkg::t_result     w_res;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == dss_pkg::S_IDLE);
    assign w_accept    = i_valid && o_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_len   <= dss_pkg::RST_TERM_LEN;
            r_term_bytes <= dss_pkg::RST_TERM_BYTES;
            r_max_len    <= dss_pkg::RST_MAX_LENGTH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dss_pkg::CFG_TERM_LEN:   r_term_len   <= i_cfg_data[3:0];
                dss_pkg::CFG_TERM_BYTES: r_term_bytes <= i_cfg_data;
                dss_pkg::CFG_MAX_LENGTH: r_max_len    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // effective terminator length, clamped to 1..MAX_TERM_BYTES
    always_comb begin
        w_len = r_term_len;
        if (r_term_len == 4'd0) begin
            w_len = 4'd1;
        end else if (r_term_len > 4'(MAX_TERM_BYTES)) begin
            w_len = 4'(MAX_TERM_BYTES);
        end
    end

    assign w_full     = (r_cnt >= r_max_len);
    assign w_term_idx = r_term_bytes[3'(r_idx)];
    assign w_term_i   = r_term_bytes[3'(r_i)];
    assign w_idx_inc  = 4'(r_idx) + 4'd1;

    // sequencer: next state and emit commands
    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        n_i             = r_i;
        n_cnt           = r_cnt;
        w_cmd.put       = 1'b0;
        w_cmd.put_byte  = 8'd0;
        w_cmd.fin       = 1'b0;
        w_cmd.fin_done  = 1'b0;
        w_cmd.fin_cause = dss_pkg::CAUSE_TERM;
        w_cmd.fin_count = r_cnt;
        case (r_state)
            dss_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = dss_pkg::S_DECIDE;
                end
            end
            dss_pkg::S_DECIDE: begin
                if (w_full) begin
                    // budget already used: input ignored
                    w_cmd.fin_done  = 1'b1;
                    w_cmd.fin_cause = dss_pkg::CAUSE_FULL;
                    if (w_stat.can_fin) begin
                        w_cmd.fin = 1'b1;
                        n_idx     = '0;
                        n_cnt     = 16'd0;
                        n_state   = dss_pkg::S_IDLE;
                    end
                end else if (!r_err && (r_c == w_term_idx)) begin
                    // next terminator byte matched, hold it back
                    if (w_idx_inc >= w_len) begin
                        w_cmd.fin_done  = 1'b1;
                        w_cmd.fin_cause = dss_pkg::CAUSE_TERM;
                        if (w_stat.can_fin) begin
                            w_cmd.fin = 1'b1;
                            n_idx     = '0;
                            n_cnt     = 16'd0;
                            n_state   = dss_pkg::S_IDLE;
                        end
                    end else begin
                        n_idx   = IW'(w_idx_inc);
                        n_state = dss_pkg::S_IDLE;
                    end
                end else begin
                    n_i     = '0;
                    n_state = dss_pkg::S_FLUSH;
                end
            end
            dss_pkg::S_FLUSH: begin
                if (r_i < r_idx) begin
                    if (w_full) begin
                        // held bytes dropped at the budget
                        w_cmd.fin_done  = 1'b1;
                        w_cmd.fin_cause = dss_pkg::CAUSE_FULL;
                        if (w_stat.can_fin) begin
                            w_cmd.fin = 1'b1;
                            n_idx     = '0;
                            n_cnt     = 16'd0;
                            n_state   = dss_pkg::S_IDLE;
                        end
                    end else if (w_stat.can_put) begin
                        w_cmd.put      = 1'b1;
                        w_cmd.put_byte = w_term_i;
                        n_cnt          = r_cnt + 16'd1;
                        n_i            = r_i + IW'(1);
                    end
                end else if (r_err || w_full) begin
                    // a read error keeps its cause when the flush fit the budget
                    w_cmd.fin_done  = 1'b1;
                    w_cmd.fin_cause = r_err ? dss_pkg::CAUSE_ERR : dss_pkg::CAUSE_FULL;
                    if (w_stat.can_fin) begin
                        w_cmd.fin = 1'b1;
                        n_idx     = '0;
                        n_cnt     = 16'd0;
                        n_state   = dss_pkg::S_IDLE;
                    end
                end else if (r_c == r_term_bytes[0]) begin
                    // naive restart on the first terminator byte
                    w_cmd.fin_done  = (w_len <= 4'd1);
                    w_cmd.fin_cause = dss_pkg::CAUSE_TERM;
                    if (w_stat.can_fin) begin
                        w_cmd.fin = 1'b1;
                        n_idx     = (w_len <= 4'd1) ? '0 : IW'(1);
                        n_cnt     = (w_len <= 4'd1) ? 16'd0 : r_cnt;
                        n_state   = dss_pkg::S_IDLE;
                    end
                end else if (w_stat.can_put) begin
                    w_cmd.put      = 1'b1;
                    w_cmd.put_byte = r_c;
                    n_cnt          = r_cnt + 16'd1;
                    n_idx          = '0;
                    n_state        = dss_pkg::S_TAIL;
                end
            end
            dss_pkg::S_TAIL: begin
                // close the run, ending the scan if the byte filled the budget
                w_cmd.fin_done  = w_full;
                w_cmd.fin_cause = dss_pkg::CAUSE_FULL;
                if (w_stat.can_fin) begin
                    w_cmd.fin = 1'b1;
                    n_idx     = '0;
                    n_cnt     = w_full ? 16'd0 : r_cnt;
                    n_state   = dss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dss_pkg::S_IDLE;
            end
        endcase
    end

    // control flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dss_pkg::S_IDLE;
            r_idx   <= '0;
            r_i     <= '0;
            r_cnt   <= 16'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_i     <= n_i;
            r_cnt   <= n_cnt;
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_c   <= i_data_byte;
            r_err <= i_read_error;
        end
    end

    dss_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_result (w_res)
    );

    assign o_out_byte    = w_res.out_byte;
    assign o_byte_valid  = w_res.byte_valid;
    assign o_scan_done   = w_res.scan_done;
    assign o_end_cause   = w_res.end_cause;
    assign o_final_count = w_res.final_count;
    assign o_last_of_run = w_res.last_of_run;

endmodule

// File: dv/delimiter_string_scanner_core_tb.sv
// Testbench for the delimiter string scanner core: directed and random streams vs. a predictor.
`timescale 1ns / 100ps

module delimiter_string_scanner_core_tb;

    localparam int          MAX_TERM      = 8;
    localparam int          ITEM_TARGET   = 350;
    localparam int          SETTLE_CYCLES = MAX_TERM + 8;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          MAX_PRINTS    = 200;
    localparam logic [1:0]  CFG_UNUSED    = 2'd3;
    localparam logic        RD_OK         = 1'b0;
    localparam logic        RD_ERR        = 1'b1;
    localparam logic [7:0]  CH_CR         = 8'h0D;
    localparam logic [7:0]  CH_LF         = 8'h0A;
    localparam logic [63:0] TERM_WXYZ     = 64'h5A59_5857;
    localparam logic [63:0] TERM_ONES     = '1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_read_error;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_scan_done;
    logic [1:0]  o_end_cause;
    logic [15:0] o_final_count;
    logic        o_last_of_run;

    // Scan predictor: register copies and scan state
    logic [3:0]       cfg_term_len;
    logic [63:0]      cfg_term;
    logic [15:0]      cfg_max_len;
    int               held_cnt;
    int               scan_bytes;
    dss_pkg::t_result run_words[$];
    dss_pkg::t_result exp_words[$];

    int          mismatches;
    int          items_sent;
    int          live_items;
    bit          tx_no_idle;
    bit          rx_no_idle;
    bit          hold_req;
    bit          hold_active;

    delimiter_string_scanner_core #(
        .MAX_TERM_BYTES(MAX_TERM)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_read_error  (i_read_error),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_scan_done   (o_scan_done),
        .o_end_cause   (o_end_cause),
        .o_final_count (o_final_count),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // terminator length in force, out-of-range values clamped
    function automatic int term_length();
        int n;
        n = int'(cfg_term_len);
        if (n < 1) n = 1;
        if (n > MAX_TERM) n = MAX_TERM;
        return n;
    endfunction

    function automatic logic [7:0] term_byte(int i);
        return cfg_term[8 * (i % 8) +: 8];
    endfunction

    function automatic void emit_payload(logic [7:0] b);
        dss_pkg::t_result w;
        w = '0;
        w.out_byte   = b;
        w.byte_valid = 1'b1;
        run_words.push_back(w);
        scan_bytes++;
    endfunction

    // end of scan goes on the last word of the run, or a word of its own
    function automatic void close_scan(dss_pkg::t_cause cause);
        dss_pkg::t_result w;
        if (run_words.size() == 0) begin
            w = '0;
            run_words.push_back(w);
        end
        w = run_words.pop_back();
        w.scan_done   = 1'b1;
        w.end_cause   = cause;
        w.final_count = scan_bytes[15:0];
        run_words.push_back(w);
        held_cnt   = 0;
        scan_bytes = 0;
    endfunction

    // emit held terminator bytes up to the budget; 1 if some were dropped
    function automatic bit flush_held(int budget);
        for (int i = 0; i < held_cnt; i++) begin
            if (scan_bytes >= budget) return 1'b1;
            emit_payload(term_byte(i));
        end
        return 1'b0;
    endfunction

    task automatic predict_word(input logic [7:0] c, input logic err);
        int               budget;
        int               len;
        bit               dropped;
        dss_pkg::t_result w;
        budget = int'(cfg_max_len);
        len    = term_length();
        run_words.delete();
        if (scan_bytes >= budget) begin
            close_scan(dss_pkg::CAUSE_FULL);
        end else if (err) begin
            live_items++;
            dropped = flush_held(budget);
            close_scan(dropped ? dss_pkg::CAUSE_FULL : dss_pkg::CAUSE_ERR);
        end else if (c == term_byte(held_cnt)) begin
            live_items++;
            held_cnt++;
            if (held_cnt >= len) close_scan(dss_pkg::CAUSE_TERM);
        end else begin
            live_items++;
            dropped = flush_held(budget);
            if (dropped || scan_bytes >= budget) begin
                close_scan(dss_pkg::CAUSE_FULL);
            end else begin
                // naive restart: only the first terminator byte is tried
                held_cnt = 0;
                if (c == term_byte(0)) begin
                    held_cnt = 1;
                    if (held_cnt >= len) close_scan(dss_pkg::CAUSE_TERM);
                end else begin
                    emit_payload(c);
                    if (scan_bytes >= budget) close_scan(dss_pkg::CAUSE_FULL);
                end
            end
        end
        if (run_words.size() > 0) begin
            w = run_words.pop_back();
            w.last_of_run = 1'b1;
            run_words.push_back(w);
        end
        foreach (run_words[i]) exp_words.push_back(run_words[i]);
    endtask

    // ---------------------------------------------------------------
    // Result side: ready pattern, long hold-off, checker
    // ---------------------------------------------------------------

    // per result word draw a random stall before ready returns
    initial begin
        int rx_wait;
        rx_wait = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) rx_wait = rx_no_idle ? 0 : $urandom_range(0, 17);
            else if (rx_wait > 0) rx_wait--;
            i_ready <= i_rst_n && !hold_active && rx_wait == 0;
        end
    end

    // long receiver hold-off, counted here
    initial begin
        hold_active = 1'b0;
        forever begin
            wait (hold_req);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active = 1'b0;
            hold_req    = 1'b0;
        end
    end

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        dss_pkg::t_result want;
        if (o_valid && i_ready) begin
            if (exp_words.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = exp_words.pop_front();
                check_field("out_byte",    32'(o_out_byte),    32'(want.out_byte));
                check_field("byte_valid",  32'(o_byte_valid),  32'(want.byte_valid));
                check_field("scan_done",   32'(o_scan_done),   32'(want.scan_done));
                check_field("end_cause",   32'(o_end_cause),   32'(want.end_cause));
                check_field("final_count", 32'(o_final_count), 32'(want.final_count));
                check_field("last_of_run", 32'(o_last_of_run), 32'(want.last_of_run));
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // valid is left high after accept; the next word or drain decides
    task automatic send_word(input logic [7:0] b, input logic err);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_read_error <= err;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        predict_word(b, err);
        items_sent++;
    endtask

    // stop offering, wait for all results, then let held work settle
    task automatic drain();
        i_valid <= 1'b0;
        while (exp_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        if (last) i_cfg_valid <= 1'b0;
        case (idx)
            dss_pkg::CFG_TERM_LEN:   cfg_term_len = val[3:0];
            dss_pkg::CFG_TERM_BYTES: cfg_term     = val;
            dss_pkg::CFG_MAX_LENGTH: cfg_max_len  = val[15:0];
            default: ;
        endcase
    endtask

    // full register set; the unused index must change nothing
    task automatic setup_regs(input logic [3:0] len, input logic [63:0] term,
                              input logic [15:0] budget);
        cfg_write(CFG_UNUSED, {$urandom, $urandom}, 1'b0);
        cfg_write(dss_pkg::CFG_TERM_LEN, {60'd0, len}, 1'b0);
        cfg_write(dss_pkg::CFG_TERM_BYTES, term, 1'b0);
        cfg_write(dss_pkg::CFG_MAX_LENGTH, {48'd0, budget}, 1'b1);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // reset registers: CR LF terminator, budget 64
    task automatic test_default_crlf();
        send_word("A", RD_OK);
        send_word(CH_CR, RD_OK);
        send_word(CH_CR, RD_OK);   // mismatch, held CR flushed, restart on CR
        send_word(CH_LF, RD_OK);
        drain();
    endtask

    task automatic test_read_error();
        send_word(CH_CR, RD_OK);
        send_word(8'hFF, RD_ERR);  // held CR flushed, ends as read error
        send_word(8'h00, RD_ERR);  // error with no payload: lone end word
        drain();
    endtask

    task automatic test_budget_limits();
        // held bytes exceed the budget
        setup_regs(4'd4, TERM_WXYZ, 16'd3);
        send_word("a", RD_OK);
        send_word("W", RD_OK);
        send_word("X", RD_OK);
        send_word("Y", RD_OK);
        send_word("b", RD_OK);
        drain();
        // flush fills the budget exactly, current byte dropped
        setup_regs(4'd4, TERM_WXYZ, 16'd2);
        send_word("a", RD_OK);
        send_word("W", RD_OK);
        send_word("q", RD_OK);
        drain();
        // budget lowered mid-scan
        setup_regs(4'd4, TERM_WXYZ, 16'd10);
        send_word("a", RD_OK);
        send_word("b", RD_OK);
        drain();
        setup_regs(4'd4, TERM_WXYZ, 16'd1);
        send_word("c", RD_OK);
        drain();
        // zero budget
        setup_regs(4'd4, TERM_WXYZ, 16'd0);
        send_word("z", RD_OK);
        drain();
        // read error while the cap drops held bytes ends as full
        setup_regs(4'd4, TERM_WXYZ, 16'd2);
        send_word("a", RD_OK);
        send_word("W", RD_OK);
        send_word("X", RD_OK);
        send_word(8'h5A, RD_ERR);
        drain();
        // read error whose flush fills the budget exactly stays a read error
        setup_regs(4'd4, TERM_WXYZ, 16'd2);
        send_word("a", RD_OK);
        send_word("W", RD_OK);
        send_word(8'h00, RD_ERR);
        drain();
    endtask

    task automatic test_term_length();
        // length 0 acts as 1
        setup_regs(4'd0, TERM_WXYZ, 16'hFFFF);
        send_word("W", RD_OK);
        drain();
        // length 15 acts as 8; seven held bytes flushed by a mismatch
        setup_regs(4'd15, TERM_ONES, 16'hFFFF);
        repeat (7) send_word(8'hFF, RD_OK);
        send_word(8'h00, RD_OK);
        drain();
        // length lowered below the held count mid-scan
        setup_regs(4'd4, TERM_WXYZ, 16'hFFFF);
        send_word("W", RD_OK);
        send_word("X", RD_OK);
        send_word("Y", RD_OK);
        drain();
        setup_regs(4'd2, TERM_WXYZ, 16'hFFFF);
        send_word("Z", RD_OK);
        drain();
        // single zero byte terminator
        setup_regs(4'd1, 64'd0, 16'd1);
        send_word(8'h00, RD_OK);
        drain();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_output_stall();
        setup_regs(4'd2, {48'd0, CH_LF, CH_CR}, 16'd64);
        tx_no_idle = 1'b1;
        hold_req   = 1'b1;
        repeat (40) send_word(8'($urandom_range(0, 255)), RD_OK);
        tx_no_idle = 1'b0;
        drain();
    endtask

    task automatic pick_scan_setup();
        logic [3:0]  len;
        logic [63:0] term;
        logic [15:0] budget;
        logic [7:0]  alpha [4];
        int          pick;
        foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick < 8) len = 4'($urandom_range(1, 8));
        else if (pick == 8) len = 4'd0;
        else len = 4'($urandom_range(9, 15));
        // a small alphabet makes partial matches frequent
        if ($urandom_range(0, 3) == 0) term = {$urandom, $urandom};
        else for (int i = 0; i < 8; i++) term[8 * i +: 8] = alpha[$urandom_range(0, 3)];
        pick = $urandom_range(0, 19);
        if (pick < 14) budget = 16'($urandom_range(1, 40));
        else if (pick < 17) budget = 16'($urandom_range(41, 300));
        else if (pick < 19) budget = 16'hFFFF;
        else budget = 16'($urandom_range(0, 2));
        drain();
        setup_regs(len, term, budget);
    endtask

    // payload with terminator fragments, mostly closed by a terminator
    task automatic run_scan();
        int len;
        int k;
        len = term_length();
        repeat ($urandom_range(0, 12)) begin
            case ($urandom_range(0, 7))
                0, 1, 2: send_word(8'($urandom_range(0, 255)), RD_OK);
                3, 4:    send_word(term_byte($urandom_range(0, len - 1)), RD_OK);
                default: begin
                    k = (len > 1) ? $urandom_range(1, len - 1) : 1;
                    for (int i = 0; i < k; i++) send_word(term_byte(i), RD_OK);
                end
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: for (int i = 0; i < len; i++) send_word(term_byte(i), RD_OK);
            7:       send_word(8'($urandom_range(0, 255)), RD_ERR);
            default: ;
        endcase
    endtask

    task automatic test_random_scans();
        int start;
        start = live_items;
        while (live_items - start < ITEM_TARGET) begin
            pick_scan_setup();
            tx_no_idle = ($urandom_range(0, 3) == 0);
            rx_no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 10)) run_scan();
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        drain();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = dss_pkg::CFG_TERM_LEN;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_data_byte  = '0;
        i_read_error = RD_OK;
        cfg_term_len = dss_pkg::RST_TERM_LEN;
        cfg_term     = dss_pkg::RST_TERM_BYTES;
        cfg_max_len  = dss_pkg::RST_MAX_LENGTH;
        held_cnt     = 0;
        scan_bytes   = 0;
        mismatches   = 0;
        items_sent   = 0;
        live_items   = 0;
        tx_no_idle   = 1'b0;
        rx_no_idle   = 1'b0;
        hold_req     = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_crlf();
        test_read_error();
        test_budget_limits();
        test_term_length();
        test_output_stall();
        test_random_scans();

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
